FILE: design/counting_semaphore_unit_top_assert.svh
// Assertion helpers for the semaphore unit; the clocked forms sample on i_clk.
`ifndef COUNTING_SEMAPHORE_UNIT_TOP_ASSERT_SVH
`define COUNTING_SEMAPHORE_UNIT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Check prop at each edge outside reset.
`define CSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check prop at every edge, reset included.
`define CSU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define CSU_ASSERT(lbl, prop, msg)
`define CSU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: design/csu_pkg.sv
package csu_pkg;

    localparam int OP_W      = 2;
    localparam int SEM_IDX_W = 8;
    localparam int TASK_W    = 4;
    localparam int CNT_W     = 16;
    localparam int ST_W      = 2;

    // Task slots that the task field can name.
    localparam int TASK_SLOTS = 2 ** TASK_W;

    localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
    localparam logic [OP_W-1:0] OP_WAIT    = 2'd1;
    localparam logic [OP_W-1:0] OP_SIGNAL  = 2'd2;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_INVAL = 2'd1;
    localparam logic [ST_W-1:0] ST_BUSY  = 2'd2;
    localparam logic [ST_W-1:0] ST_PERM  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [SEM_IDX_W-1:0] sem_index;
        logic [TASK_W-1:0]    task_id;
        logic [CNT_W-1:0]     initial_value;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic              caller_blocked;
        logic              woken_valid;
        logic [TASK_W-1:0] woken_task;
        logic              woken_interrupted;
        logic              last;
    } t_res;

endpackage

FILE: design/counting_semaphore_unit_top.sv
// The first result word loads in S_LOOK, or in S_LINK or S_WALK when the link RAM is read first.
// A new request is taken only in S_IDLE, once the last one is done; a signal that releases a
// waiter with others behind it passes through S_LINK. A destroy with waiters releases them in
// S_WALK over the link RAM, one waiter per cycle while the output register is free. The pace is
// set by the registered read of the semaphore RAM and of the link RAM. Reset (synchronous,
// active low) clears the active, queued and waiting flags. RAM contents are not cleared.
module counting_semaphore_unit_top
    import csu_pkg::*;
#(
    parameter int NUM_SEMS  = 16,
    parameter int NUM_TASKS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_word,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_res o_out_word
);
    `include "counting_semaphore_unit_top_assert.svh"

    // Only the first TASK_SLOTS tasks can ever be named by the task field.
    localparam int NT  = (NUM_TASKS < TASK_SLOTS) ? NUM_TASKS : TASK_SLOTS;
    localparam int TIW = $clog2(NT);
    localparam int SW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int EW  = CNT_W + 3 * TIW;

    // One semaphore RAM entry: count, owner, queue head and queue tail.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [TIW-1:0]   owner;
        logic [TIW-1:0]   head;
        logic [TIW-1:0]   tail;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_LINK,
        S_WALK
    } t_state;

    t_state r_state, n_state;
    t_req   r_req;
    logic [TIW-1:0] r_cur, n_cur;
    logic [TIW-1:0] r_guard, n_guard;

    // Per-entry flags in flops so reset clears them at once.
    logic [NUM_SEMS-1:0] r_active;
    logic [NUM_SEMS-1:0] r_nonempty;
    logic [NT-1:0]       r_waiting;

    logic in_accept;
    logic out_free;
    logic out_load;
    t_res n_word;

    t_entry sem_rd, sem_wdata;
    logic   sem_we;
    logic [EW-1:0] sem_rd_bits;

    logic [TIW-1:0] link_rd;
    logic           link_we;
    logic [TIW-1:0] link_waddr;
    logic [TIW-1:0] link_wdata;
    logic           link_re;
    logic [TIW-1:0] link_raddr;

    logic act_set, act_clr, ne_set, ne_clr, wait_set, wait_clr;
    logic [TIW-1:0] wait_clr_idx;

    logic [SW-1:0]  s_idx;
    logic [TIW-1:0] t_idx;
    logic           sem_ok;
    logic           task_ok;
    logic           sem_live;
    logic           walk_end;

    // Take a request only between requests; all state updates of one request
    // land before the next one reads the RAMs, so no forwarding is needed.
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    assign s_idx    = r_req.sem_index[SW-1:0];
    assign t_idx    = r_req.task_id[TIW-1:0];
    assign sem_ok   = {1'b0, r_req.sem_index} < (SEM_IDX_W + 1)'(NUM_SEMS);
    assign task_ok  = {1'b0, r_req.task_id} < (TASK_W + 1)'(NT);
    assign sem_live = sem_ok && r_active[s_idx];
    assign sem_rd   = t_entry'(sem_rd_bits);

    // Semaphore table: read on accept, written back when the result goes out.
    csu_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_SEMS)
    ) u_sem_ram (
        .i_clk   (i_clk),
        .i_we    (sem_we),
        .i_waddr (s_idx),
        .i_wdata (sem_wdata),
        .i_re    (in_accept),
        .i_raddr (i_in_word.sem_index[SW-1:0]),
        .o_rdata (sem_rd_bits)
    );

    // Wait-queue links: entry t names the task queued behind task t.
    csu_ram #(
        .WIDTH (TIW),
        .DEPTH (NT)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rd)
    );

    csu_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_word  (n_word),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_guard      = r_guard;
        out_load     = 1'b0;
        n_word       = '0;
        n_word.last  = 1'b1;
        sem_we       = 1'b0;
        sem_wdata    = sem_rd;
        link_we      = 1'b0;
        link_waddr   = sem_rd.tail;
        link_wdata   = t_idx;
        link_re      = 1'b0;
        link_raddr   = sem_rd.head;
        act_set      = 1'b0;
        act_clr      = 1'b0;
        ne_set       = 1'b0;
        ne_clr       = 1'b0;
        wait_set     = 1'b0;
        wait_clr     = 1'b0;
        wait_clr_idx = sem_rd.head;
        walk_end     = (r_cur == sem_rd.tail) || (r_guard == TIW'(NT - 1));

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_LOOK;
                end
            end

            // Semaphore entry is on the RAM output; decide and write back.
            S_LOOK: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    if (!task_ok) begin
                        n_word.status = ST_INVAL;
                    end else begin
                        case (r_req.operation)
                            OP_INIT: begin
                                if (!sem_ok) begin
                                    n_word.status = ST_INVAL;
                                end else if (r_active[s_idx]) begin
                                    n_word.status = ST_BUSY;
                                end else begin
                                    sem_we          = 1'b1;
                                    sem_wdata.count = r_req.initial_value;
                                    sem_wdata.owner = t_idx;
                                    act_set         = 1'b1;
                                    ne_clr          = 1'b1;
                                end
                            end

                            OP_WAIT: begin
                                if (r_req.task_id == '0) begin
                                    n_word.status = ST_PERM;
                                end else if (!sem_live) begin
                                    n_word.status = ST_INVAL;
                                end else if (sem_rd.count != '0) begin
                                    sem_we          = 1'b1;
                                    sem_wdata.count = sem_rd.count - CNT_W'(1);
                                end else if (r_waiting[t_idx]) begin
                                    n_word.status = ST_BUSY;
                                end else begin
                                    // Append the caller at the queue tail.
                                    if (r_nonempty[s_idx]) begin
                                        link_we = 1'b1;
                                    end else begin
                                        sem_wdata.head = t_idx;
                                    end
                                    sem_wdata.tail        = t_idx;
                                    sem_we                = 1'b1;
                                    ne_set                = 1'b1;
                                    wait_set              = 1'b1;
                                    n_word.caller_blocked = 1'b1;
                                end
                            end

                            OP_SIGNAL: begin
                                if (!sem_live) begin
                                    n_word.status = ST_INVAL;
                                end else if (r_nonempty[s_idx]) begin
                                    if (sem_rd.head == sem_rd.tail) begin
                                        // Sole waiter: empty the queue.
                                        ne_clr             = 1'b1;
                                        wait_clr           = 1'b1;
                                        n_word.woken_valid = 1'b1;
                                        n_word.woken_task  = TASK_W'(sem_rd.head);
                                    end else begin
                                        // Fetch the successor before releasing the head.
                                        out_load = 1'b0;
                                        link_re  = 1'b1;
                                        n_state  = S_LINK;
                                    end
                                end else if (sem_rd.count != '1) begin
                                    sem_we          = 1'b1;
                                    sem_wdata.count = sem_rd.count + CNT_W'(1);
                                end
                            end

                            OP_DESTROY: begin
                                if (!sem_live) begin
                                    n_word.status = ST_INVAL;
                                end else if (sem_rd.owner != t_idx) begin
                                    n_word.status = ST_PERM;
                                end else if (!r_nonempty[s_idx]) begin
                                    act_clr = 1'b1;
                                end else begin
                                    // Start the waiter walk at the head.
                                    out_load = 1'b0;
                                    link_re  = 1'b1;
                                    n_cur    = sem_rd.head;
                                    n_guard  = '0;
                                    n_state  = S_WALK;
                                end
                            end

                            default: begin
                                n_word.status = ST_INVAL;
                            end
                        endcase
                    end
                end
            end

            // Successor of the head is on the link RAM output.
            S_LINK: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    sem_we             = 1'b1;
                    sem_wdata.head     = link_rd;
                    wait_clr           = 1'b1;
                    n_word.woken_valid = 1'b1;
                    n_word.woken_task  = TASK_W'(sem_rd.head);
                    n_state            = S_IDLE;
                end
            end

            // Release one waiter per cycle while the output register is free; the link RAM output names the next one.
            S_WALK: begin
                if (out_free) begin
                    out_load                 = 1'b1;
                    wait_clr                 = 1'b1;
                    wait_clr_idx             = r_cur;
                    n_word.woken_valid       = 1'b1;
                    n_word.woken_task        = TASK_W'(r_cur);
                    n_word.woken_interrupted = 1'b1;
                    n_word.last              = walk_end;
                    if (walk_end) begin
                        ne_clr  = 1'b1;
                        act_clr = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        link_re    = 1'b1;
                        link_raddr = link_rd;
                        n_cur      = link_rd;
                        n_guard    = r_guard + TIW'(1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_active   <= '0;
            r_nonempty <= '0;
            r_waiting  <= '0;
        end else begin
            r_state <= n_state;
            if (act_set) begin
                r_active[s_idx] <= 1'b1;
            end
            if (act_clr) begin
                r_active[s_idx] <= 1'b0;
            end
            if (ne_set) begin
                r_nonempty[s_idx] <= 1'b1;
            end
            if (ne_clr) begin
                r_nonempty[s_idx] <= 1'b0;
            end
            if (wait_set) begin
                r_waiting[t_idx] <= 1'b1;
            end
            if (wait_clr) begin
                r_waiting[wait_clr_idx] <= 1'b0;
            end
        end
        if (in_accept) begin
            r_req <= i_in_word;
        end
        r_cur   <= n_cur;
        r_guard <= n_guard;
    end

    `CSU_ASSERT(a_accept_to_look, in_accept |=> (r_state == S_LOOK), "accepted request did not start a lookup")
    `CSU_ASSERT(a_walk_queue_live, (r_state == S_WALK) |-> r_nonempty[s_idx], "walk over an empty queue")
    `CSU_ASSERT(a_block_sets_wait, (out_load && n_word.caller_blocked) |=> r_waiting[t_idx], "blocked caller not marked waiting")
    `CSU_ASSERT_ALWAYS(a_block_xor_wake, !i_rst_n || !(o_out_valid && o_out_word.caller_blocked && o_out_word.woken_valid), "result both blocks and wakes")

endmodule

FILE: design/csu_ram.sv
module csu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/csu_out_reg.sv
module csu_out_reg
    import csu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_res i_word,
    output logic o_free,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_word
);
    logic r_valid;
    t_res r_word;

    // Free when empty or when the held word leaves at this edge.
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import csu_pkg::*;

    localparam int NUM_SEMS     = 16;
    localparam int NUM_TASKS    = 16;
    localparam int IDLE_PCT     = 19;
    localparam int REPORT_MAX   = 10;
    localparam int RANDOM_ITEMS = 56;
    // A destroy of a full queue is short, and so are stalls and gaps.
    // A long stretch without any handshake can only mean a hang.
    localparam int STUCK_LIMIT  = 4000;
    // Let the output register settle after the last word before judging.
    localparam int TAIL_CYCLES  = 24;
    localparam logic [CNT_W-1:0] COUNT_TOP = '1;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_req i_in_word   = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_res o_out_word;

    // High while a stretch runs with no idling on either side.
    bit quiet        = 1'b0;
    int n_mismatch   = 0;
    int stuck_cycles = 0;

    // Reply words owed by the block, oldest first.
    t_res replies_due[$];

    // Shadow of the semaphore bank.
    logic              sem_on  [NUM_SEMS];
    logic [CNT_W-1:0]  sem_cnt [NUM_SEMS];
    logic [TASK_W-1:0] sem_own [NUM_SEMS];
    logic [TASK_W-1:0] q_head  [NUM_SEMS];
    logic [TASK_W-1:0] q_tail  [NUM_SEMS];
    logic              q_busy  [NUM_SEMS];
    logic [TASK_W-1:0] link    [NUM_TASKS];
    logic              parked  [NUM_TASKS];

    counting_semaphore_unit_top #(
        .NUM_SEMS (NUM_SEMS),
        .NUM_TASKS(NUM_TASKS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_res mk_reply(input logic [ST_W-1:0] st, input logic blk,
                                      input logic wv, input logic [TASK_W-1:0] wt,
                                      input logic wi, input logic lst);
        t_res r;
        r.status            = st;
        r.caller_blocked    = blk;
        r.woken_valid       = wv;
        r.woken_task        = wt;
        r.woken_interrupted = wi;
        r.last              = lst;
        return r;
    endfunction

    // Advance the shadow bank by one request and queue the reply words it owes.
    task automatic apply_sem_request(input t_req req);
        int                s;
        int                g;
        int                woken;
        bit                sem_ok;
        logic              fin;
        logic [TASK_W-1:0] who;
        logic [TASK_W-1:0] cur;
        s      = int'(req.sem_index);
        who    = req.task_id;
        sem_ok = s < NUM_SEMS;
        woken  = 0;
        if (int'(who) >= NUM_TASKS) begin
            replies_due.push_back(mk_reply(ST_INVAL, 1'b0, 1'b0, '0, 1'b0, 1'b1));
        end else if (req.operation == OP_INIT) begin
            if (!sem_ok) begin
                replies_due.push_back(mk_reply(ST_INVAL, 1'b0, 1'b0, '0, 1'b0, 1'b1));
            end else if (sem_on[s]) begin
                replies_due.push_back(mk_reply(ST_BUSY, 1'b0, 1'b0, '0, 1'b0, 1'b1));
            end else begin
                sem_on[s]  = 1'b1;
                sem_cnt[s] = req.initial_value;
                sem_own[s] = who;
                q_busy[s]  = 1'b0;
                replies_due.push_back(mk_reply(ST_OK, 1'b0, 1'b0, '0, 1'b0, 1'b1));
            end
        end else if (req.operation == OP_WAIT) begin
            if (who == '0) begin
                // The initial task may never block; refuse before anything else.
                replies_due.push_back(mk_reply(ST_PERM, 1'b0, 1'b0, '0, 1'b0, 1'b1));
            end else if (!sem_ok || !sem_on[s]) begin
                replies_due.push_back(mk_reply(ST_INVAL, 1'b0, 1'b0, '0, 1'b0, 1'b1));
            end else if (sem_cnt[s] != '0) begin
                sem_cnt[s] = sem_cnt[s] - 1'b1;
                replies_due.push_back(mk_reply(ST_OK, 1'b0, 1'b0, '0, 1'b0, 1'b1));
            end else if (parked[who]) begin
                // A task sits in one queue at most.
                replies_due.push_back(mk_reply(ST_BUSY, 1'b0, 1'b0, '0, 1'b0, 1'b1));
            end else begin
                if (q_busy[s])
                    link[q_tail[s]] = who;
                else
                    q_head[s] = who;
                q_tail[s]   = who;
                q_busy[s]   = 1'b1;
                parked[who] = 1'b1;
                replies_due.push_back(mk_reply(ST_OK, 1'b1, 1'b0, '0, 1'b0, 1'b1));
            end
        end else if (!sem_ok || !sem_on[s]) begin
            replies_due.push_back(mk_reply(ST_INVAL, 1'b0, 1'b0, '0, 1'b0, 1'b1));
        end else if (req.operation == OP_SIGNAL) begin
            if (q_busy[s]) begin
                cur = q_head[s];
                if (cur == q_tail[s])
                    q_busy[s] = 1'b0;
                else
                    q_head[s] = link[cur];
                parked[cur] = 1'b0;
                replies_due.push_back(mk_reply(ST_OK, 1'b0, 1'b1, cur, 1'b0, 1'b1));
            end else begin
                // Saturate at the top of the count.
                if (sem_cnt[s] != COUNT_TOP)
                    sem_cnt[s] = sem_cnt[s] + 1'b1;
                replies_due.push_back(mk_reply(ST_OK, 1'b0, 1'b0, '0, 1'b0, 1'b1));
            end
        end else if (sem_own[s] != who) begin
            replies_due.push_back(mk_reply(ST_PERM, 1'b0, 1'b0, '0, 1'b0, 1'b1));
        end else begin
            // Destroy: release every waiter in queue order, flagged as interrupted.
            if (q_busy[s]) begin
                cur = q_head[s];
                for (g = 0; g < NUM_TASKS; g++) begin
                    fin = (cur == q_tail[s]) || (g == NUM_TASKS - 1);
                    parked[cur] = 1'b0;
                    replies_due.push_back(mk_reply(ST_OK, 1'b0, 1'b1, cur, 1'b1, fin));
                    woken++;
                    if (fin)
                        break;
                    cur = link[cur];
                end
            end
            q_busy[s] = 1'b0;
            sem_on[s] = 1'b0;
            if (woken == 0)
                replies_due.push_back(mk_reply(ST_OK, 1'b0, 1'b0, '0, 1'b0, 1'b1));
        end
    endtask

    // Sample the request channel: every accepted word moves the shadow bank.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_stall === 1'b0)
            apply_sem_request(i_in_word);
    end

    task automatic note_mismatch(input string why, input t_res want, input t_res got);
        n_mismatch++;
        if (n_mismatch <= REPORT_MAX)
            $display({"%0t %s: want st=%0d blk=%0b wv=%0b wt=%0d wi=%0b last=%0b,",
                      " got st=%0d blk=%0b wv=%0b wt=%0d wi=%0b last=%0b"},
                     $time, why, want.status, want.caller_blocked, want.woken_valid,
                     want.woken_task, want.woken_interrupted, want.last,
                     got.status, got.caller_blocked, got.woken_valid,
                     got.woken_task, got.woken_interrupted, got.last);
    endtask

    // Sample the reply channel and hold each word against the oldest one owed.
    always @(posedge i_clk) begin : check_replies
        t_res want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                note_mismatch("reply word with nothing owed", '0, o_out_word);
            end else begin
                want = replies_due.pop_front();
                if (o_out_word.status !== want.status
                        || o_out_word.caller_blocked !== want.caller_blocked
                        || o_out_word.woken_valid !== want.woken_valid
                        || o_out_word.woken_task !== want.woken_task
                        || o_out_word.woken_interrupted !== want.woken_interrupted
                        || o_out_word.last !== want.last)
                    note_mismatch("reply word mismatch", want, o_out_word);
            end
        end
    end

    // Stall the reply channel at random, except during a quiet stretch.
    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99, 0) < IDLE_PCT);
    end

    // Count cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // Watchdog: end the run once the channels have been silent too long.
    initial begin
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one request word and hold it until the block takes it.
    // Valid stays high on return so back-to-back words need no extra edge.
    task automatic send_req(input logic [OP_W-1:0] op, input int sem, input int who,
                            input int val);
        t_req req;
        req.operation     = op;
        req.sem_index     = SEM_IDX_W'(sem);
        req.task_id       = TASK_W'(who);
        req.initial_value = CNT_W'(val);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99, 0) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= req;
        do
            @(posedge i_clk);
        while (o_in_stall !== 1'b0);
    endtask

    // Refuse requests on an empty bank and out-of-range indexes.
    task automatic test_refusals();
        send_req(OP_WAIT, 0, 0, 0);
        send_req(OP_SIGNAL, 0, 3, 0);
        send_req(OP_DESTROY, 0, 3, 0);
        send_req(OP_INIT, 255, 15, 65535);
    endtask

    // Drive the top semaphore to the count ceiling and tear it down by its owner.
    task automatic test_count_ceiling();
        send_req(OP_INIT, NUM_SEMS - 1, 15, 65535);
        send_req(OP_INIT, NUM_SEMS - 1, 4, 0);
        send_req(OP_SIGNAL, NUM_SEMS - 1, 6, 0);
        send_req(OP_WAIT, NUM_SEMS - 1, 1, 0);
        send_req(OP_DESTROY, NUM_SEMS - 1, 2, 0);
        send_req(OP_DESTROY, NUM_SEMS - 1, 15, 0);
    endtask

    // Queue waiters, refuse a second wait by a queued task, wake in order.
    task automatic test_fifo_order();
        send_req(OP_INIT, 0, 0, 1);
        send_req(OP_WAIT, 0, 1, 0);
        send_req(OP_WAIT, 0, 2, 0);
        send_req(OP_WAIT, 0, 3, 0);
        send_req(OP_WAIT, 0, 2, 0);
        send_req(OP_SIGNAL, 0, 1, 0);
        send_req(OP_WAIT, 0, 4, 0);
        send_req(OP_WAIT, 16, 5, 0);
        send_req(OP_DESTROY, 0, 0, 0);
        send_req(OP_SIGNAL, 0, 1, 0);
    endtask

    // Wake a lone waiter, then count up on an empty queue.
    task automatic test_single_wake();
        send_req(OP_INIT, 1, 9, 0);
        send_req(OP_WAIT, 1, 14, 0);
        send_req(OP_SIGNAL, 1, 9, 0);
        send_req(OP_SIGNAL, 1, 9, 0);
    endtask

    // Fill one queue with every task but task 0 in shuffled order, cycle its head, then destroy.
    // Run without idling so the walk of the full queue goes back to back.
    task automatic test_deep_queue(input int sem);
        int order [NUM_TASKS-1];
        int i;
        int j;
        int tmp;
        int owner;
        quiet = 1'b1;
        if (sem_on[sem])
            send_req(OP_DESTROY, sem, sem_own[sem], 0);
        owner = $urandom_range(NUM_TASKS - 1, 0);
        send_req(OP_INIT, sem, owner, 0);
        for (i = 0; i < NUM_TASKS - 1; i++)
            order[i] = i + 1;
        for (i = NUM_TASKS - 2; i > 0; i--) begin
            j        = $urandom_range(i, 0);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < NUM_TASKS - 1; i++)
            send_req(OP_WAIT, sem, order[i], 0);
        send_req(OP_SIGNAL, sem, owner, 0);
        send_req(OP_WAIT, sem, order[0], 0);
        send_req(OP_DESTROY, sem, owner, 0);
        quiet = 1'b0;
    endtask

    // Mostly well-formed traffic on a few semaphores, with raw noise mixed in.
    task automatic test_random_traffic(input int items);
        int kind;
        int s;
        int who;
        int val;
        repeat (items) begin
            kind = $urandom_range(9, 0);
            s    = $urandom_range(3, 0);
            who  = $urandom_range(NUM_TASKS - 1, 1);
            case ($urandom_range(4, 0))
                0: val = 0;
                1: val = 1;
                2: val = 2;
                3: val = 65535;
                default: val = $urandom_range(65535, 0);
            endcase
            case (kind)
                0, 1: begin
                    send_req(OP_W'($urandom_range(3, 0)), $urandom_range(255, 0),
                             $urandom_range(NUM_TASKS - 1, 0), $urandom_range(65535, 0));
                end
                2, 9: begin
                    send_req(OP_INIT, s, $urandom_range(NUM_TASKS - 1, 0), val);
                end
                3, 4, 5: begin
                    send_req(OP_WAIT, s, who, val);
                end
                6, 7: begin
                    send_req(OP_SIGNAL, s, who, val);
                end
                default: begin
                    // Mostly let the owner destroy, so queues actually drain.
                    if (sem_on[s] && $urandom_range(9, 0) < 8)
                        send_req(OP_DESTROY, s, sem_own[s], val);
                    else
                        send_req(OP_DESTROY, s, who, val);
                end
            endcase
        end
    endtask

    // Drop valid and wait for every owed word, then a short tail.
    task automatic drain_replies();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES)
            @(posedge i_clk);
    endtask

    initial begin
        // Clear the shadow flags; the rest is written before it is read.
        for (int i = 0; i < NUM_SEMS; i++) begin
            sem_on[i] = 1'b0;
            q_busy[i] = 1'b0;
        end
        for (int i = 0; i < NUM_TASKS; i++)
            parked[i] = 1'b0;

        // Hold reset, then release it at a falling edge.
        repeat (7)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_refusals();
        test_count_ceiling();
        test_fifo_order();
        test_single_wake();
        test_deep_queue($urandom_range(NUM_SEMS - 1, 4));
        test_random_traffic(RANDOM_ITEMS);
        test_deep_queue($urandom_range(NUM_SEMS - 1, 4));
        drain_replies();

        if (n_mismatch == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: counting_semaphore_unit_top.f
+incdir+design
design/csu_pkg.sv
design/csu_ram.sv
design/csu_out_reg.sv
design/counting_semaphore_unit_top.sv
test/tb_top.sv
